/* rtl/dsfp_pkg.sv */
// Package for the dollar-sentence field parser: sizes, character codes, sentence kinds,
// the result structure and the keyword match function.
// Used by dsfp_parse and the top level; has no dependencies.
package dsfp_pkg;

    localparam int TERM_CAPACITY = 32;
    localparam int FILL_W        = $clog2(TERM_CAPACITY);

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam logic [3:0] KIND_NONE = 4'd0;
    localparam logic [3:0] KIND_LOC  = 4'd1;
    localparam logic [3:0] KIND_HRM  = 4'd2;
    localparam logic [3:0] KIND_CAD  = 4'd3;
    localparam logic [3:0] KIND_ANCS = 4'd4;
    localparam logic [3:0] KIND_DWN  = 4'd5;
    localparam logic [3:0] KIND_BTN  = 4'd6;
    localparam logic [3:0] KIND_DBG  = 4'd7;
    localparam logic [3:0] KIND_QRY  = 4'd8;

    localparam logic [1:0] DBG_TYPE_ZERO  = 2'd0;
    localparam logic [1:0] DBG_TYPE_ONE   = 2'd1;
    localparam logic [1:0] DBG_TYPE_OTHER = 2'd2;

    // Keyword text, first character in the lowest byte.
    localparam logic [31:0] KEY_TEXT [8] = '{
        32'h00434F4C, 32'h004D5248, 32'h00444143, 32'h53434E41,
        32'h004E5744, 32'h004E5442, 32'h00474244, 32'h00595251
    };
    localparam logic [2:0] KEY_LEN [8] = '{3'd3, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3};

    typedef struct packed {
        logic [31:0] field_value;
        logic [3:0]  term_index;
        logic [3:0]  sentence_kind;
        logic        field_valid;
        logic [3:0]  completed_kind;
    } t_result;

    // The first keyword that has the stored term as a prefix wins.
    function automatic logic [3:0] match_kind(input logic [FILL_W-1:0] fill,
                                              input logic [31:0] head);
        logic [3:0] kind;
        logic       ok;
        kind = KIND_NONE;
        for (int k = 7; k >= 0; k--) begin
            ok = ({{(32-FILL_W){1'b0}}, fill} <= 32'(KEY_LEN[k]));
            for (int i = 0; i < 4; i++) begin
                if (i < int'(fill) && head[8*i +: 8] != KEY_TEXT[k][8*i +: 8]) begin
                    ok = 1'b0;
                end
            end
            if (ok) begin
                kind = 4'(k + 1);
            end
        end
        return kind;
    endfunction

endpackage

/* rtl/dsfp_in_stage.sv */
// Input register of the dollar-sentence field parser: holds one character beat.
// Does not use dsfp_pkg; no submodules.
module dsfp_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_char
);
    logic       r_valid;
    logic [7:0] r_char;

    assign o_s_tready = !r_valid || i_advance;
    assign o_valid    = r_valid;
    assign o_char     = r_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_char <= i_s_tdata;
        end
    end

endmodule

/* rtl/dsfp_parse.sv */
// Sentence state and single-pass parse logic of the dollar-sentence field parser.
// Depends on dsfp_pkg; the state advances on each character step.
module dsfp_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_char,
    output dsfp_pkg::t_result   o_res
);
    import dsfp_pkg::*;

    logic              r_active, n_active;
    logic [3:0]        r_kind, n_kind;
    logic [3:0]        r_term, n_term;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [31:0]       r_head, n_head;
    logic [31:0]       r_accum, n_accum;
    logic              r_minus, n_minus;
    logic              r_ended, n_ended;
    logic              r_notice_zero, n_notice_zero;
    logic [1:0]        r_dbg_type, n_dbg_type;

    logic              is_term;
    logic              room;
    logic [31:0]       val_u;
    logic [31:0]       val_s;
    logic [7:0]        digit;
    t_result           res;

    assign is_term = (i_char == CH_COMMA) || (i_char == CH_CR) ||
                     (i_char == CH_LF) || (i_char == CH_STAR);
    assign room    = r_fill < FILL_W'(TERM_CAPACITY - 1);
    assign val_u   = r_minus ? 32'd0 : r_accum;
    assign val_s   = r_minus ? (32'd0 - r_accum) : r_accum;
    assign digit   = i_char - CH_ZERO;

    always_comb begin
        n_active      = r_active;
        n_kind        = r_kind;
        n_term        = r_term;
        n_fill        = r_fill;
        n_head        = r_head;
        n_accum       = r_accum;
        n_minus       = r_minus;
        n_ended       = r_ended;
        n_notice_zero = r_notice_zero;
        n_dbg_type    = r_dbg_type;
        res           = '0;

        if (is_term) begin
            if (r_active) begin
                res.term_index = r_term;
                if (room) begin
                    if (r_term == 4'd0) begin
                        n_kind = match_kind(r_fill, r_head);
                    end else if (r_kind != KIND_NONE && r_fill != '0) begin
                        case (r_kind)
                            KIND_LOC: begin
                                if (r_term == 4'd1) begin
                                    res.field_valid = 1'b1;
                                    res.field_value = val_u;
                                end else if (r_term >= 4'd2 && r_term <= 4'd5) begin
                                    res.field_valid = 1'b1;
                                    res.field_value = val_s;
                                    if (r_term == 4'd5) begin
                                        res.completed_kind = KIND_LOC;
                                    end
                                end
                            end
                            KIND_HRM, KIND_CAD: begin
                                if (r_term == 4'd1 || r_term == 4'd2) begin
                                    res.field_valid = 1'b1;
                                    res.field_value = val_u;
                                    if (r_term == 4'd2) begin
                                        res.completed_kind = r_kind;
                                    end
                                end
                            end
                            KIND_ANCS: begin
                                if (r_term == 4'd1) begin
                                    res.field_valid = 1'b1;
                                    res.field_value = val_u;
                                    n_notice_zero   = (val_u == 32'd0);
                                end else if ((r_term == 4'd2 && r_notice_zero) ||
                                             r_term == 4'd3) begin
                                    res.completed_kind = KIND_ANCS;
                                end
                            end
                            KIND_DWN: begin
                                if (r_term == 4'd1) begin
                                    res.field_valid    = 1'b1;
                                    res.field_value    = val_u;
                                    res.completed_kind = KIND_DWN;
                                end
                            end
                            KIND_BTN: begin
                                if (r_term == 4'd1) begin
                                    res.field_valid    = 1'b1;
                                    res.field_value    = val_u + 32'd1;
                                    res.completed_kind = KIND_BTN;
                                end
                            end
                            KIND_DBG: begin
                                if (r_term >= 4'd1 && r_term <= 4'd3) begin
                                    res.field_valid = 1'b1;
                                    res.field_value = val_u;
                                end
                                if (r_term == 4'd1) begin
                                    n_dbg_type = (val_u == 32'd0) ? DBG_TYPE_ZERO :
                                                 (val_u == 32'd1) ? DBG_TYPE_ONE :
                                                 DBG_TYPE_OTHER;
                                end
                                if ((r_term == 4'd3 && r_dbg_type == DBG_TYPE_ZERO) ||
                                    (r_term == 4'd4 && r_dbg_type == DBG_TYPE_ONE)) begin
                                    res.completed_kind = KIND_DBG;
                                end
                            end
                            KIND_QRY: begin
                                if (r_term == 4'd1) begin
                                    res.field_valid = 1'b1;
                                    res.field_value = val_u;
                                end else if (r_term == 4'd2) begin
                                    res.completed_kind = KIND_QRY;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                if (r_term != 4'd15) begin
                    n_term = r_term + 4'd1;
                end
            end
            n_fill  = '0;
            n_head  = '0;
            n_accum = '0;
            n_minus = 1'b0;
            n_ended = 1'b0;
            if (res.completed_kind != KIND_NONE) begin
                n_active = 1'b0;
            end
        end else if (i_char == CH_DOLLAR) begin
            n_fill   = '0;
            n_head   = '0;
            n_accum  = '0;
            n_minus  = 1'b0;
            n_ended  = 1'b0;
            n_term   = 4'd0;
            n_active = 1'b1;
            n_kind   = KIND_NONE;
        end else if (r_active && room) begin
            if (r_fill < FILL_W'(4)) begin
                n_head[{r_fill[1:0], 3'b000} +: 8] = i_char;
            end
            if (r_fill == '0 && i_char == CH_MINUS) begin
                n_minus = 1'b1;
            end else if (!r_ended && (i_char inside {[8'h30:8'h39]})) begin
                n_accum = (r_accum << 3) + (r_accum << 1) + {24'd0, digit};
            end else begin
                n_ended = 1'b1;
            end
            n_fill = r_fill + FILL_W'(1);
        end

        res.sentence_kind = n_kind;
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= 1'b0;
            r_kind        <= KIND_NONE;
            r_term        <= 4'd0;
            r_fill        <= '0;
            r_head        <= '0;
            r_accum       <= '0;
            r_minus       <= 1'b0;
            r_ended       <= 1'b0;
            r_notice_zero <= 1'b1;
            r_dbg_type    <= DBG_TYPE_ZERO;
        end else if (i_step) begin
            r_active      <= n_active;
            r_kind        <= n_kind;
            r_term        <= n_term;
            r_fill        <= n_fill;
            r_head        <= n_head;
            r_accum       <= n_accum;
            r_minus       <= n_minus;
            r_ended       <= n_ended;
            r_notice_zero <= n_notice_zero;
            r_dbg_type    <= n_dbg_type;
        end
    end

`ifndef NO_ASSERTIONS
    a_done_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && res.completed_kind != KIND_NONE) |->
        (res.sentence_kind == res.completed_kind))
        else $error("completed kind differs from sentence kind");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && res.completed_kind != KIND_NONE) |=> !r_active)
        else $error("parser still active after a completed sentence");
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !res.field_valid) |-> (res.field_value == 32'd0))
        else $error("value reported without a valid field");
    a_field_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && res.field_valid) |-> (res.term_index != 4'd0 && r_kind != KIND_NONE))
        else $error("field reported for the kind term or an unknown sentence");
`endif

endmodule

/* rtl/dollar_sentence_field_parser.sv */
// Top level of the dollar-sentence field parser: input register, parse stage, result register.
// Depends on dsfp_pkg, dsfp_in_stage and dsfp_parse.
//
// The parser takes one character beat per clock and gives exactly one result beat for each
// character, in order. A character passes the input register, is parsed against the sentence
// state combinationally and lands in the result register, from which it is presented as a result beat;
// the sustained rate is one character per cycle whenever the result side is taking beats.
// Sentences start with '$', terms end at ',', '*', CR or LF, the first term selects the
// sentence kind, and numeric terms are reported as 32-bit values.
module dollar_sentence_field_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] char_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] completed_kind, [4] field_valid, [8:5] sentence_kind, [12:9] term_index,
    // [44:13] field_value, [47:45] zero
    output logic [47:0] m_axis_tdata
);
    import dsfp_pkg::*;

    logic    advance;
    logic    in_valid;
    logic    step;
    logic [7:0] in_char;
    t_result parse_res;
    t_result r_res;
    logic    r_out_valid;

    assign advance = !r_out_valid || m_axis_tready;
    assign step    = in_valid && advance;

    dsfp_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_advance  (advance),
        .o_valid    (in_valid),
        .o_char     (in_char)
    );

    dsfp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_char  (in_char),
        .o_res   (parse_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= parse_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_res};

endmodule
